### hw/rtl/c3dc_pkg.sv
// shared types and constants of the 3x3 rgb convolution core
// no dependencies

package c3dc_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COEF_BITS  = 8;
   localparam int ADDR_W     = $clog2(2 * MAX_WIDTH);
   // product of a signed coefficient and a 9-bit signed sample, plus growth over nine terms
   localparam int SUM_W      = COEF_BITS + 9 + 4;
   localparam int MAG_W      = SUM_W - 1;
   localparam int STEP_W     = $clog2(MAG_W);
   localparam int TAPS       = 9;

   localparam logic [2:0] CSR_COEF_TOP = 3'd0;
   localparam logic [2:0] CSR_COEF_MID = 3'd1;
   localparam logic [2:0] CSR_COEF_BOT = 3'd2;
   localparam logic [2:0] CSR_DIVISOR  = 3'd3;
   localparam logic [2:0] CSR_WIDTH    = 3'd4;
   localparam logic [2:0] CSR_HEIGHT   = 3'd5;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [9:0] out_row;
      logic [9:0] out_col;
      logic       frame_last;
   } rsp_type;

   typedef logic [TAPS-1:0][7:0]           pix9_type;
   typedef logic [TAPS-1:0][COEF_BITS-1:0] coef9_type;

   typedef struct packed {
      logic       start;
      pix9_type   pix;
      coef9_type  coef;
      logic [9:0] divisor;
   } lane_ctl_type;

   typedef struct packed {
      logic       done;
      logic [7:0] value;
   } lane_sts_type;

endpackage

### hw/rtl/c3dc_wincell.sv
// one row of the 3x3 window: two column taps shifted in step with the pixel stream
// no dependencies

module c3dc_wincell (
   input  logic        clock,
   input  logic        reset,
   input  logic        shift,
   input  logic [23:0] din,
   output logic [23:0] tap0,
   output logic [23:0] tap1
);

   logic [23:0] tap0_ff, tap0_in;
   logic [23:0] tap1_ff, tap1_in;

   always_comb begin
      tap0_in = tap0_ff;
      tap1_in = tap1_ff;
      if (shift) begin
         tap0_in = tap1_ff;
         tap1_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap0_ff <= '0;
         tap1_ff <= '0;
      end else begin
         tap0_ff <= tap0_in;
         tap1_ff <= tap1_in;
      end
   end

   assign tap0 = tap0_ff;
   assign tap1 = tap1_ff;

endmodule

### hw/rtl/c3dc_lane.sv
// one color channel: nine-step multiply-accumulate, restoring divide, clamp
// depends on c3dc_pkg

module c3dc_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  c3dc_pkg::lane_ctl_type ctl,
   output c3dc_pkg::lane_sts_type sts
);

   typedef enum logic [2:0] {
      L_IDLE = 3'b001,
      L_MAC  = 3'b010,
      L_DIV  = 3'b100
   } lane_state_type;

   lane_state_type state_ff, state_in;
   logic [c3dc_pkg::STEP_W-1:0]        step_ff, step_in;
   c3dc_pkg::pix9_type                 pix_ff, pix_in;
   c3dc_pkg::coef9_type                coef_ff, coef_in;
   logic [9:0]                         div_ff, div_in;
   logic signed [c3dc_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic                               neg_ff, neg_in;
   logic [c3dc_pkg::MAG_W-1:0]         mag_ff, mag_in;
   logic [9:0]                         rem_ff, rem_in;
   logic [7:0]                         val_ff, val_in;
   logic                               done_ff, done_in;

   logic signed [c3dc_pkg::COEF_BITS+8:0] prod;
   logic signed [c3dc_pkg::SUM_W-1:0]     sum_next;
   logic signed [c3dc_pkg::SUM_W-1:0]     abs_v;
   logic [10:0]                           rem_sh;
   logic                                  ge;
   logic [c3dc_pkg::MAG_W-1:0]            quo;

   always_comb begin
      prod = $signed(coef_ff[step_ff[3:0]]) * $signed({1'b0, pix_ff[step_ff[3:0]]});
      sum_next = acc_ff + c3dc_pkg::SUM_W'(prod);
      abs_v = sum_next[c3dc_pkg::SUM_W-1] ? -sum_next : sum_next;
      rem_sh = {rem_ff, mag_ff[c3dc_pkg::MAG_W-1]};
      ge = (rem_sh >= {1'b0, div_ff});
      quo = {mag_ff[c3dc_pkg::MAG_W-2:0], ge};

      state_in = state_ff;
      step_in  = step_ff;
      pix_in   = pix_ff;
      coef_in  = coef_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      val_in   = val_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         L_IDLE: begin
            if (ctl.start) begin
               pix_in   = ctl.pix;
               coef_in  = ctl.coef;
               // zero divisor acts as one
               div_in   = (ctl.divisor == 10'd0) ? 10'd1 : ctl.divisor;
               acc_in   = '0;
               step_in  = '0;
               state_in = L_MAC;
            end
         end
         L_MAC: begin
            acc_in  = sum_next;
            step_in = step_ff + 1'b1;
            if (step_ff == c3dc_pkg::STEP_W'(c3dc_pkg::TAPS - 1)) begin
               neg_in   = sum_next[c3dc_pkg::SUM_W-1];
               mag_in   = abs_v[c3dc_pkg::MAG_W-1:0];
               rem_in   = '0;
               step_in  = '0;
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            rem_in  = ge ? 10'(rem_sh - {1'b0, div_ff}) : rem_sh[9:0];
            mag_in  = quo;
            step_in = step_ff + 1'b1;
            if (step_ff == c3dc_pkg::STEP_W'(c3dc_pkg::MAG_W - 1)) begin
               // quotient truncates toward zero, so any negative sum clamps to zero
               if (neg_ff)
                  val_in = 8'd0;
               else if (quo > c3dc_pkg::MAG_W'(255))
                  val_in = 8'd255;
               else
                  val_in = quo[7:0];
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      pix_ff  <= pix_in;
      coef_ff <= coef_in;
      div_ff  <= div_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      val_ff  <= val_in;
   end

   assign sts.done  = done_ff;
   assign sts.value = val_ff;

endmodule

### hw/rtl/rgb_conv3x3_div_clamp_core.sv
// top level of the 3x3 rgb convolution with divide and clamp
// depends on c3dc_pkg, c3dc_wincell, c3dc_lane

// Pixels enter in raster order; each interior pixel's 3x3 neighborhood gives one
// filtered pixel, border pixels give none, and frame_last marks the last result of a
// frame. A pixel in row or column 0 or 1 holds the block for its transfer and line store
// read; any other for the read, nine multiply-accumulate steps and a 20-step restoring
// divide that the three per-color lanes run side by side, and the move to the output
// register. The result register lets the next pixel be taken while a result waits on
// rsp_ready. Configuration must be written while idle; not enforced by the block.
module rgb_conv3x3_div_clamp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  c3dc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output c3dc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_CALC = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [23:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [9:0]  divisor_ff;
   logic [10:0] width_ff, height_ff;

   logic [9:0]  row_ff, row_in, col_ff, col_in;
   logic [9:0]  out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic        last_ff, last_in, emit_ff, emit_in;
   logic [23:0] cur_ff, cur_in;
   logic [23:0] rd_top_ff, rd_mid_ff;
   logic [23:0] line_mem [2*c3dc_pkg::MAX_WIDTH];

   logic              rsp_valid_ff, rsp_valid_in;
   c3dc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic [10:0] w_eff, h_eff;
   logic row_end, frame_end;
   logic [c3dc_pkg::ADDR_W-1:0] slot_cur, slot_prev;
   logic [23:0] cur_pix;
   logic        shift;
   logic [23:0] w0, w1, w2, w3, w4, w5;
   logic [8:0][23:0] win;
   c3dc_pkg::coef9_type coef9;
   c3dc_pkg::lane_ctl_type ctl_r, ctl_g, ctl_b;
   c3dc_pkg::lane_sts_type sts_r, sts_g, sts_b;

   assign accept  = req_valid && req_ready;
   assign cur_pix = {req_data.pixel_blue, req_data.pixel_green, req_data.pixel_red};

   always_comb begin
      if (width_ff < 11'd3)
         w_eff = 11'd3;
      else if (width_ff > 11'(c3dc_pkg::MAX_WIDTH))
         w_eff = 11'(c3dc_pkg::MAX_WIDTH);
      else
         w_eff = width_ff;
      if (height_ff < 11'd3)
         h_eff = 11'd3;
      else if (height_ff > 11'(c3dc_pkg::MAX_HEIGHT))
         h_eff = 11'(c3dc_pkg::MAX_HEIGHT);
      else
         h_eff = height_ff;
      row_end   = ({1'b0, col_ff} >= (w_eff - 11'd1));
      frame_end = row_end && ({1'b0, row_ff} >= (h_eff - 11'd1));
      // even rows in the low half of the line store, odd rows in the high half
      slot_cur  = c3dc_pkg::ADDR_W'(row_ff[0] ? c3dc_pkg::MAX_WIDTH : 0)
                  + c3dc_pkg::ADDR_W'(col_ff);
      slot_prev = c3dc_pkg::ADDR_W'(row_ff[0] ? 0 : c3dc_pkg::MAX_WIDTH)
                  + c3dc_pkg::ADDR_W'(col_ff);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= 24'd0;
         coef_mid_ff <= 24'd256;
         coef_bot_ff <= 24'd0;
         divisor_ff  <= 10'd1;
         width_ff    <= 11'd1024;
         height_ff   <= 11'd1024;
      end else if (csr_we) begin
         unique case (csr_index)
            c3dc_pkg::CSR_COEF_TOP: coef_top_ff <= csr_wdata;
            c3dc_pkg::CSR_COEF_MID: coef_mid_ff <= csr_wdata;
            c3dc_pkg::CSR_COEF_BOT: coef_bot_ff <= csr_wdata;
            c3dc_pkg::CSR_DIVISOR:  divisor_ff  <= csr_wdata[9:0];
            c3dc_pkg::CSR_WIDTH:    width_ff    <= csr_wdata[10:0];
            c3dc_pkg::CSR_HEIGHT:   height_ff   <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // line store: read both rows before the current pixel overwrites its slot
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_top_ff          <= line_mem[slot_cur];
         rd_mid_ff          <= line_mem[slot_prev];
         line_mem[slot_cur] <= cur_pix;
      end
   end

   assign shift = (state_ff == ST_LOAD);

   c3dc_wincell u_cell_top (.clock, .reset, .shift, .din(rd_top_ff), .tap0(w0), .tap1(w1));
   c3dc_wincell u_cell_mid (.clock, .reset, .shift, .din(rd_mid_ff), .tap0(w2), .tap1(w3));
   c3dc_wincell u_cell_bot (.clock, .reset, .shift, .din(cur_ff),    .tap0(w4), .tap1(w5));

   always_comb begin
      win = {cur_ff, w5, w4, rd_mid_ff, w3, w2, rd_top_ff, w1, w0};
      for (int j = 0; j < 3; j++) begin
         coef9[j]   = coef_top_ff[c3dc_pkg::COEF_BITS*j +: c3dc_pkg::COEF_BITS];
         coef9[3+j] = coef_mid_ff[c3dc_pkg::COEF_BITS*j +: c3dc_pkg::COEF_BITS];
         coef9[6+j] = coef_bot_ff[c3dc_pkg::COEF_BITS*j +: c3dc_pkg::COEF_BITS];
      end
      ctl_r.start = shift && emit_ff;
      ctl_r.coef = coef9;
      ctl_r.divisor = divisor_ff;
      ctl_g = ctl_r;
      ctl_b = ctl_r;
      for (int k = 0; k < c3dc_pkg::TAPS; k++) begin
         ctl_r.pix[k] = win[k][7:0];
         ctl_g.pix[k] = win[k][15:8];
         ctl_b.pix[k] = win[k][23:16];
      end
   end

   c3dc_lane u_lane_r (.clock, .reset, .ctl(ctl_r), .sts(sts_r));
   c3dc_lane u_lane_g (.clock, .reset, .ctl(ctl_g), .sts(sts_g));
   c3dc_lane u_lane_b (.clock, .reset, .ctl(ctl_b), .sts(sts_b));

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      last_in      = last_ff;
      emit_in      = emit_ff;
      cur_in       = cur_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in     = cur_pix;
               emit_in    = (row_ff >= 10'd2) && (col_ff >= 10'd2);
               out_row_in = row_ff - 10'd1;
               out_col_in = col_ff - 10'd1;
               last_in    = frame_end;
               if (frame_end) begin
                  row_in = '0;
                  col_in = '0;
               end else if (row_end) begin
                  row_in = row_ff + 10'd1;
                  col_in = '0;
               end else begin
                  col_in = col_ff + 10'd1;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = emit_ff ? ST_CALC : ST_IDLE;
         ST_CALC: if (sts_r.done) state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.out_red    = sts_r.value;
               rsp_data_in.out_green  = sts_g.value;
               rsp_data_in.out_blue   = sts_b.value;
               rsp_data_in.out_row    = out_row_ff;
               rsp_data_in.out_col    = out_col_ff;
               rsp_data_in.frame_last = last_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      last_ff     <= last_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/rgb_conv3x3_div_clamp_core_tb.sv
// self-checking testbench of the 3x3 rgb convolution core
// depends on c3dc_pkg and rgb_conv3x3_div_clamp_core
`timescale 1ns / 100ps

module rgb_conv3x3_div_clamp_core_tb;

   localparam int LIMIT   = 600000;
   localparam int SETTLE  = 40;
   localparam int N_ITEMS = 1750;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   c3dc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   c3dc_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = c3dc_pkg::CSR_COEF_TOP;
   logic [23:0]       csr_wdata = '0;

   rgb_conv3x3_div_clamp_core dut (.*);

   always #4 clock = ~clock;

   // filter state as the block should hold it
   logic [23:0] kern_top, kern_mid, kern_bot;
   logic [9:0]  div_reg;
   logic [10:0] width_reg, height_reg;
   logic [23:0] line_mem [2*c3dc_pkg::MAX_WIDTH];
   logic [23:0] win [6];
   logic [9:0]  row_pos, col_pos;

   c3dc_pkg::rsp_type pixel_q [$];
   int      errors = 0;
   int      pixels_sent = 0;
   int      pixels_out = 0;
   int      frames_done = 0;
   int      cycles = 0;
   bit      hold_go = 0, hold_done = 0;
   int      hold_cnt = 0;

   function automatic logic [7:0] filter_chan(input logic [8:0][23:0] p, input int sh,
                                              input int dv);
      int sum;
      logic [23:0] rr;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         rr = (i == 0) ? kern_top : (i == 1) ? kern_mid : kern_bot;
         for (int j = 0; j < 3; j++)
            sum += int'($signed(rr[8*j +: 8])) * int'(p[i*3+j][sh +: 8]);
      end
      if (dv != 1) sum = sum / dv;
      if (sum < 0) sum = 0;
      else if (sum > 255) sum = 255;
      return sum[7:0];
   endfunction

   task automatic predict_pixel(input c3dc_pkg::req_type px, output bit got,
                                output c3dc_pkg::rsp_type r);
      int w, h, c, dv, s_cur, s_prv;
      logic [23:0] cur, top, mid;
      logic [8:0][23:0] p;
      bit row_end, frame_end;
      w = width_reg; h = height_reg; c = col_pos;
      dv = (div_reg == 0) ? 1 : div_reg;
      if (w < 3) w = 3;
      if (w > c3dc_pkg::MAX_WIDTH) w = c3dc_pkg::MAX_WIDTH;
      if (h < 3) h = 3;
      if (h > c3dc_pkg::MAX_HEIGHT) h = c3dc_pkg::MAX_HEIGHT;
      if (c >= c3dc_pkg::MAX_WIDTH) c = c3dc_pkg::MAX_WIDTH - 1;
      cur = {px.pixel_blue, px.pixel_green, px.pixel_red};
      s_cur = (row_pos[0] ? c3dc_pkg::MAX_WIDTH : 0) + c;
      s_prv = (row_pos[0] ? 0 : c3dc_pkg::MAX_WIDTH) + c;
      top = line_mem[s_cur];
      mid = line_mem[s_prv];
      line_mem[s_cur] = cur;
      row_end = (c >= w - 1);
      frame_end = row_end && (row_pos >= h - 1);
      got = (row_pos >= 2) && (c >= 2);
      r = '0;
      if (got) begin
         p = {cur, win[5], win[4], mid, win[3], win[2], top, win[1], win[0]};
         r.out_red    = filter_chan(p, 0, dv);
         r.out_green  = filter_chan(p, 8, dv);
         r.out_blue   = filter_chan(p, 16, dv);
         r.out_row    = row_pos - 10'd1;
         r.out_col    = 10'(c - 1);
         r.frame_last = frame_end;
      end
      win[0] = win[1]; win[1] = top;
      win[2] = win[3]; win[3] = mid;
      win[4] = win[5]; win[5] = cur;
      if (frame_end) begin
         row_pos = 0; col_pos = 0; frames_done++;
      end else if (row_end) begin
         row_pos = row_pos + 10'd1; col_pos = 0;
      end else begin
         col_pos = 10'(c + 1);
      end
   endtask

   // register write, applied at the edge; caller lowers csr_we after the batch
   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         c3dc_pkg::CSR_COEF_TOP: kern_top = val;
         c3dc_pkg::CSR_COEF_MID: kern_mid = val;
         c3dc_pkg::CSR_COEF_BOT: kern_bot = val;
         c3dc_pkg::CSR_DIVISOR:  div_reg = val[9:0];
         c3dc_pkg::CSR_WIDTH:    width_reg = val[10:0];
         c3dc_pkg::CSR_HEIGHT:   height_reg = val[10:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_filter(input logic [23:0] t, m, b, input logic [9:0] dv,
                             input logic [10:0] w, h);
      drain();
      write_reg(c3dc_pkg::CSR_COEF_TOP, t);
      write_reg(c3dc_pkg::CSR_COEF_MID, m);
      write_reg(c3dc_pkg::CSR_COEF_BOT, b);
      write_reg(c3dc_pkg::CSR_DIVISOR, {14'd0, dv});
      write_reg(c3dc_pkg::CSR_WIDTH, {13'd0, w});
      write_reg(c3dc_pkg::CSR_HEIGHT, {13'd0, h});
      csr_we <= 1'b0;
   endtask

   // sender in bursts with gaps
   int burst_left = 0;

   task automatic send_pixel(input c3dc_pkg::req_type px, input bit typed,
                             input c3dc_pkg::rsp_type typed_rsp);
      bit got;
      c3dc_pkg::rsp_type r;
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (!req_ready);
      predict_pixel(px, got, r);
      pixels_sent++;
      if (got) pixel_q.push_back(typed ? typed_rsp : r);
      if (pixels_sent > 300 && !hold_go) hold_go = 1;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic c3dc_pkg::req_type rand_pixel();
      return c3dc_pkg::req_type'(24'($urandom_range(0, 24'hffffff)));
   endfunction

   task automatic send_rest_of_frame;
      do send_pixel(rand_pixel(), 0, '0); while (row_pos != 0 || col_pos != 0);
   endtask

   function automatic logic [23:0] rand_kern();
      logic [23:0] k;
      case ($urandom_range(0, 5))
         0: k = 24'h808080;
         1: k = 24'h7f7f7f;
         2: k = $urandom;
         default: begin
            for (int j = 0; j < 3; j++) k[8*j +: 8] = 8'($signed($urandom_range(0, 8)) - 4);
         end
      endcase
      return k;
   endfunction

   // receiver stall pattern, with one long hold-off
   int rx_mode = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_go && !hold_done) begin
         hold_cnt = 400;
         hold_done = 1;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer %p", rsp_data);
         end else begin
            c3dc_pkg::rsp_type e;
            e = pixel_q.pop_front();
            pixels_out++;
            if (rsp_data !== e) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p got %p", e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   // identity kernel after reset on a 5x5 frame: each result is the center pixel
   typedef struct {
      logic [23:0]       px;
      bit                typed;
      c3dc_pkg::rsp_type res;
   } dir_row_t;

   function automatic c3dc_pkg::rsp_type mk(input logic [23:0] rgb, input int r, c,
                                            input bit l);
      return c3dc_pkg::rsp_type'({rgb, 10'(r), 10'(c), l});
   endfunction

   dir_row_t dir_tab [25];

   initial begin
      dir_row_t d;
      logic [23:0] pix_vals [25];
      pix_vals = '{
         24'h000000, 24'hffffff, 24'h800000, 24'h008000, 24'h000080,
         24'h7f7f7f, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'h010203,
         24'haa55aa, 24'h55aa55, 24'hffffff, 24'h000000, 24'h123456,
         24'h808080, 24'h7f8001, 24'hfe01fe, 24'h01fe01, 24'h3c3c3c,
         24'hc0ffee, 24'h0f0f0f, 24'hf0f0f0, 24'ha5a5a5, 24'h5a5a5a};
      for (int k = 0; k < 25; k++) dir_tab[k] = '{pix_vals[k], 0, '0};
      dir_tab[12].typed = 1; dir_tab[12].res = mk(24'hff0000, 1, 1, 0);
      dir_tab[13].typed = 1; dir_tab[13].res = mk(24'h00ff00, 1, 2, 0);
      dir_tab[14].typed = 1; dir_tab[14].res = mk(24'h0000ff, 1, 3, 0);
      dir_tab[17].typed = 1; dir_tab[17].res = mk(24'h55aa55, 2, 1, 0);
      dir_tab[18].typed = 1; dir_tab[18].res = mk(24'hffffff, 2, 2, 0);
      dir_tab[19].typed = 1; dir_tab[19].res = mk(24'h000000, 2, 3, 0);
      dir_tab[22].typed = 1; dir_tab[22].res = mk(24'h7f8001, 3, 1, 0);
      dir_tab[23].typed = 1; dir_tab[23].res = mk(24'hfe01fe, 3, 2, 0);
      dir_tab[24].typed = 1; dir_tab[24].res = mk(24'h01fe01, 3, 3, 1);

      kern_top = 0; kern_mid = 24'h000100; kern_bot = 0;
      div_reg = 1; width_reg = 1024; height_reg = 1024;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      row_pos = 0; col_pos = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // only the geometry is written, the kernel stays at its reset value
      write_reg(c3dc_pkg::CSR_WIDTH, 24'd5);
      write_reg(c3dc_pkg::CSR_HEIGHT, 24'd5);
      csr_we <= 1'b0;
      // table values are written red, green, blue from the high byte down
      foreach (dir_tab[k]) begin
         d = dir_tab[k];
         send_pixel(c3dc_pkg::req_type'(d.px), d.typed, d.res);
      end

      // clamp high and low, divisor zero and maximum, geometry saturation
      set_filter(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 10'd1, 11'd3, 11'd3);
      send_rest_of_frame();
      set_filter(24'h808080, 24'h808080, 24'h808080, 10'd0, 11'd2, 11'd0);
      send_rest_of_frame();
      set_filter(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 10'd1023, 11'd4, 11'd3);
      send_rest_of_frame();

      // oversized geometry, then shrunk mid-frame
      set_filter(24'h00ff00, 24'hff04ff, 24'h00ff00, 10'd1, 11'd2047, 11'd2047);
      repeat (10) send_pixel(rand_pixel(), 0, '0);
      drain();
      write_reg(c3dc_pkg::CSR_WIDTH, 24'd6);
      csr_we <= 1'b0;
      repeat (13) send_pixel(rand_pixel(), 0, '0);
      drain();
      write_reg(c3dc_pkg::CSR_HEIGHT, 24'd3);
      csr_we <= 1'b0;
      send_rest_of_frame();

      while (pixels_sent < N_ITEMS) begin
         int w, h, dsel;
         logic [9:0] dv;
         w = ($urandom_range(0, 9) != 0) ? $urandom_range(3, 10) : $urandom_range(11, 64);
         h = $urandom_range(3, 6);
         if ($urandom_range(0, 19) == 0) begin w = $urandom_range(100, 200); h = 3; end
         dsel = $urandom_range(0, 19);
         dv = (dsel < 6) ? 10'd1 : (dsel == 6) ? 10'd0 : (dsel == 7) ? 10'd1023
              : 10'($urandom_range(2, 64));
         set_filter(rand_kern(), rand_kern(), rand_kern(), dv, 11'(w), 11'(h));
         send_rest_of_frame();
      end
      req_valid <= 1'b0;
      drain();

      if (pixel_q.size() != 0) errors++;
      $display("%0d pixels in %0d frames gave %0d filtered pixels, %0d cycles",
               pixels_sent, frames_done, pixels_out, cycles);
      $display("kernels, divisors and frame sizes varied, with stalls on both sides");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule
